// File: hw/rtl/i2dec_pkg.sv
// i2dec_pkg: shared types and constants for the signed integer to decimal
// ascii converter. No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package i2dec_pkg;

  // field widths
  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 7;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  // bcd conversion geometry
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int IDX_W      = 4;
  localparam int STEP_BITS  = 4;
  localparam int NUM_STEPS  = VALUE_W / STEP_BITS;
  localparam int STEP_CNT_W = $clog2(NUM_STEPS);

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

  // packed bcd register, digit 0 is the units place
  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_FIND = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage

// File: hw/rtl/i2dec_dabble.sv
// i2dec_dabble: shift-and-add-3 step unit, folds four binary bits into a
// ten digit bcd accumulator. Depends on i2dec_pkg.
`timescale 1ns / 1ps

module i2dec_dabble (
  input  i2dec_pkg::bcd_t                       bcd_i,
  input  logic [i2dec_pkg::STEP_BITS-1:0]       bits_i,
  output i2dec_pkg::bcd_t                       bcd_o
);
  import i2dec_pkg::*;

  // four dependent adjust-and-shift passes, each over ten independent digits
  always_comb begin
    bcd_t                            acc;
    logic [NUM_DIGITS*DIGIT_W-1:0]   flat;
    acc = bcd_i;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (acc[d] >= 4'd5) begin
          acc[d] = acc[d] + 4'd3;
        end
      end
      flat = acc;
      acc  = bcd_t'({flat[NUM_DIGITS*DIGIT_W-2:0], bits_i[STEP_BITS-1-s]});
    end
    bcd_o = acc;
  end

endmodule

// File: hw/rtl/signed_int_to_decimal_ascii.sv
// signed_int_to_decimal_ascii: top level, sequencer around the shared bcd
// step unit and the character output. Depends on i2dec_pkg, i2dec_dabble.
// Conversion: 8 passes of the shared shift-add-3 unit (4 bits per pass),
//   then a find step to locate the leading digit.
// Output: n = 1..11 characters per number, emitted at one per cycle while
//   out_tready is high; in_tready stays low until the last one is taken.
// Reset: synchronous active-low rst_n returns the sequencer to idle.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: value[31:0]
  input  logic [i2dec_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_tdata: char_code[6:0], zero[7]
  output logic [i2dec_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                               out_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready
);
  import i2dec_pkg::*;

  state_t                  state_r, state_nxt;
  logic [VALUE_W-1:0]      bin_r, bin_nxt;
  bcd_t                    bcd_r, bcd_nxt;
  bcd_t                    bcd_step;
  logic [STEP_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [IDX_W-1:0]        msd_idx;
  logic                    sign_r, sign_nxt;
  logic [VALUE_W-1:0]      mag;
  logic [CHAR_W-1:0]       char_code;
  logic                    in_xact;
  logic                    out_xact;

  // shared conversion unit
  i2dec_dabble u_dabble (
    .bcd_i  (bcd_r),
    .bits_i (bin_r[VALUE_W-1 -: STEP_BITS]),
    .bcd_o  (bcd_step)
  );

  // magnitude of the input taken as unsigned
  assign mag = in_tdata[VALUE_W-1] ? (VALUE_W'(0) - in_tdata) : in_tdata;

  // leading nonzero digit, units place when the value is zero
  always_comb begin
    msd_idx = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_r[d] != '0) begin
        msd_idx = IDX_W'(d);
      end
    end
  end

  // handshake and output payload
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_EMIT);
  assign in_xact    = in_tvalid && in_tready;
  assign out_xact   = out_tvalid && out_tready;
  assign char_code  = sign_r ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(bcd_r[idx_r]));
  assign out_tdata  = {1'b0, char_code};
  assign out_tlast  = !sign_r && (idx_r == '0);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    sign_nxt  = sign_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xact) begin
          bin_nxt   = mag;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          sign_nxt  = in_tdata[VALUE_W-1];
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = bcd_step;
        bin_nxt = {bin_r[VALUE_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_CNT_W'(NUM_STEPS - 1)) begin
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        idx_nxt   = msd_idx;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_xact) begin
          if (sign_r) begin
            sign_nxt = 1'b0;
          end else if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      sign_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sign_r  <= sign_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  // input and output never handshake-ready together
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while emitting");

  // first character appears once the conversion passes and the find step have followed the input transaction
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_xact |-> ##10 out_tvalid)
    else $error("first character late");

  // final character is always a digit
  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[CHAR_W-1:0] >= CHAR_ZERO))
    else $error("last character not a digit");

  // minus sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[CHAR_W-1:0] == CHAR_MINUS) |-> !out_tlast)
    else $error("minus sign marked last");

  // a stalled digit index never moves
  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(idx_r) && $stable(sign_r))
    else $error("index moved under stall");

endmodule

// File: tb/decimal_text_checker.sv
// decimal_text_checker: watches both stream channels of the integer to decimal
// text converter, predicts the character sequence and compares it.
// Depends on i2dec_pkg for the character codes.
`timescale 1ns / 1ps

module decimal_text_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [31:0] in_tdata,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] out_tdata,
  input  logic       out_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  output int         mismatch_count,
  output int         chars_pending
);
  import i2dec_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  text_char_t expected_chars[$];
  text_char_t want;
  int         errors = 0;

  // expand one number into its characters, sign first, no leading zeros
  function automatic void predict_text(input logic [31:0] value);
    logic [31:0] mag;
    logic [3:0]  digit_q[$];
    text_char_t  c;
    int          i;
    mag = value[31] ? (32'd0 - value) : value;
    do begin
      digit_q.push_front(4'(mag % 32'd10));
      mag = mag / 32'd10;
    end while (mag != 32'd0);
    if (value[31]) begin
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    for (i = 0; i < digit_q.size(); i++) begin
      c.code = CHAR_ZERO + CHAR_W'(digit_q[i]);
      c.last = (i == digit_q.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_text(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character: expected none, got tdata %0d last %0b",
                   $time, out_tdata, out_tlast);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_tdata != {1'b0, want.code}) begin
            $display("%0t: char_code mismatch: expected %0d, got tdata %0d",
                     $time, want.code, out_tdata);
            errors++;
          end
          if (out_tlast != want.last) begin
            $display("%0t: last mismatch: expected %0b, got %0b",
                     $time, want.last, out_tlast);
            errors++;
          end
        end
      end
    end
    mismatch_count <= errors;
    chars_pending  <= expected_chars.size();
  end

endmodule

// File: tb/testbench.sv
// testbench: clock, reset and stimulus for signed_int_to_decimal_ascii, with
// random idling on both channels. Depends on the block and decimal_text_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 88;

  logic        clk = 1'b0;
  logic        rst_n;
  logic [31:0] in_tdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready;
  int          mismatch_count;
  int          chars_pending;
  int          cycles = 0;
  logic        steady = 1'b0;

  signed_int_to_decimal_ascii dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  decimal_text_checker text_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tdata       (in_tdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver backpressure, random stalls outside the steady stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= 9);
    end
  end

  // one input transaction, with optional idle cycles ahead of it
  task automatic send_value(input logic [31:0] value);
    while (!steady && $urandom_range(0, 99) < 9) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
  endtask

  // hold the sender off until every character has come out
  task automatic drain_text();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (chars_pending != 0);
  endtask

  // random value with a random digit count, sign and boundary bias
  function automatic logic [31:0] pick_value();
    int          ndig;
    int unsigned pow10;
    logic [31:0] mag;
    ndig  = $urandom_range(1, 10);
    pow10 = 1;
    repeat (ndig - 1) pow10 = pow10 * 10;
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: mag = (ndig == 1) ? $urandom_range(0, 9) :
               (ndig == 10) ? $urandom_range(32'd2147483647, 32'd1000000000) :
               $urandom_range(pow10 * 10 - 1, pow10);
      2: mag = pow10 - $urandom_range(0, 1);
      default: mag = $urandom_range(0, 999);
    endcase
    return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
  endfunction

  initial begin
    logic [31:0] directed_q[$];
    int          n;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, zero, single digits and the five-to-six-digit boundary
    directed_q = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
                   32'd99999, 32'd100000, 32'd100123, 32'hFFFE_78E5, 32'd100001,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                   32'd999999999, 32'd2000000005, 32'd12345, 32'hFFFF_FFF9,
                   32'h5555_5555, 32'hAAAA_AAAA, 32'd1000000};
    foreach (directed_q[i]) begin
      send_value(directed_q[i]);
    end
    drain_text();

    // random part, with a stretch free of idling in the middle
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      steady <= (n >= 40 && n < 70);
      if (n == 80) begin
        drain_text();
      end
      send_value(pick_value());
    end
    steady <= 1'b0;

    // wait for the remaining characters, then a short tail
    drain_text();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
